FILE: design/blws_pkg.sv
// ----------------------------------------------------------------------------
// blws_pkg: shared definitions for the bounded list with sort
// Action and status codes, cell command codes, the control bundle that the
// sequencer broadcasts to the row of list cells, and parameter defaults.
// ----------------------------------------------------------------------------
package blws_pkg;

	// Fixed field widths of the item and result ports.
	localparam int ACTION_WIDTH = 3;
	localparam int VALUE_WIDTH  = 32;
	localparam int POS_WIDTH    = 4;
	localparam int STATUS_WIDTH = 2;

	// Parameter defaults.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Actions carried by an input item.
	localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_WIDTH-1:0] ACT_READ       = 3'd4;
	localparam logic [ACTION_WIDTH-1:0] ACT_REVERSE    = 3'd5;
	localparam logic [ACTION_WIDTH-1:0] ACT_SORT       = 3'd6;
	localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR      = 3'd7;

	// Result status codes.
	localparam logic [STATUS_WIDTH-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_WIDTH-1:0] STAT_RANGE = 2'd3;

	// Commands to the cell row.
	localparam int CMD_WIDTH = 3;
	localparam logic [CMD_WIDTH-1:0] CMD_HOLD       = 3'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_SHIFT_UP   = 3'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_SHIFT_DOWN = 3'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_WRITE      = 3'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_TAG        = 3'd4;
	localparam logic [CMD_WIDTH-1:0] CMD_PHASE      = 3'd5;

	typedef struct packed {
		logic [CMD_WIDTH-1:0] cmd;     // what every cell does this cycle
		logic                 parity;  // which pairs compare in a phase
		logic                 by_tag;  // order by position tag, not by value
	} cell_ctl_t;

endpackage

FILE: design/blws_cell.sv
// ----------------------------------------------------------------------------
// blws_cell: one list position
// Holds one entry and its position tag, shifts with its neighbors, and
// acts as either half of a compare-and-swap pair during sort phases.
// ----------------------------------------------------------------------------
module blws_cell #(
	parameter int DEPTH      = blws_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = blws_pkg::DATA_WIDTH_DEF,
	parameter int INDEX      = 0
) (
	input  logic                         clk,
	input  blws_pkg::cell_ctl_t          ctl,
	input  logic [DATA_WIDTH-1:0]        din,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  logic [DATA_WIDTH-1:0]        left_data,
	input  logic [$clog2(DEPTH)-1:0]     left_tag,
	input  logic [DATA_WIDTH-1:0]        right_data,
	input  logic [$clog2(DEPTH)-1:0]     right_tag,
	input  logic                         swap_left,
	output logic                         swap_right,
	output logic [DATA_WIDTH-1:0]        data,
	output logic [$clog2(DEPTH)-1:0]     tag
);
	import blws_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [DATA_WIDTH-1:0] data_q;
	logic [IW-1:0]         tag_q;
	logic                  pair_active;
	logic                  out_of_order;

	// This cell pairs with its right neighbor when both hold entries and the
	// phase parity matches the cell's own index parity.
	assign pair_active = (ctl.cmd == CMD_PHASE) && (1'(INDEX % 2) == ctl.parity) &&
		(CW'(INDEX + 1) < count);
	assign out_of_order = ctl.by_tag ? (tag_q < right_tag) :
		($signed(right_data) < $signed(data_q));
	assign swap_right = pair_active && out_of_order;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_SHIFT_UP: begin
				data_q <= left_data;
			end
			CMD_SHIFT_DOWN: begin
				data_q <= right_data;
			end
			CMD_WRITE: begin
				if (count == CW'(INDEX)) begin
					data_q <= din;
				end
			end
			CMD_TAG: begin
				tag_q <= IW'(INDEX);
			end
			CMD_PHASE: begin
				if (swap_left) begin
					data_q <= left_data;
					tag_q  <= left_tag;
				end else if (swap_right) begin
					data_q <= right_data;
					tag_q  <= right_tag;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	assign tag  = tag_q;

endmodule

FILE: design/bounded_list_with_sort.sv
// ----------------------------------------------------------------------------
// bounded_list_with_sort: bounded ordered list of signed entries
// A row of list cells with a small sequencer; supports push, pop, read,
// reverse, stable ascending sort and clear, one result item per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (action, value, position) enter on in_valid / in_stall and
//   results leave on out_valid / out_stall; an item moves at a clock edge
//   where valid is high and stall is low. Every input item gives exactly one
//   result item with the popped or read value, front and back entries, the
//   count, an empty flag and a status.
//   Push, pop, read and clear update the list cells at the accepting edge
//   and form the result in the report state that follows; the block takes
//   no new item until that result is formed.
//   Reverse and sort run one odd-even transposition phase per entry held,
//   then leave the sort state for the report state. Reverse tags every
//   cell with its position and sorts the tags in descending order.
//   The result sits in an output register, so the next item is accepted
//   while a result waits. If the receiver stalls and a second result is
//   ready, the sequencer holds in its report cycle and in_stall stays high.
//   Reset empties the list and drops any pending result; entry contents are
//   not cleared, since no position at or beyond the count is ever read.
// ----------------------------------------------------------------------------
module bounded_list_with_sort #(
	parameter int DEPTH      = blws_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = blws_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [blws_pkg::ACTION_WIDTH-1:0]   action,
	input  logic signed [blws_pkg::VALUE_WIDTH-1:0] value,
	input  logic [blws_pkg::POS_WIDTH-1:0]      position,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [blws_pkg::VALUE_WIDTH-1:0] result_value,
	output logic signed [blws_pkg::VALUE_WIDTH-1:0] front_value,
	output logic signed [blws_pkg::VALUE_WIDTH-1:0] back_value,
	output logic [$clog2(DEPTH+1)-1:0]          count,
	output logic                                is_empty,
	output logic [blws_pkg::STATUS_WIDTH-1:0]   status
);
	import blws_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SORT   = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;

	logic [1:0]              state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [CW-1:0]           phases_q, phases_d;
	logic                    parity_q, parity_d;
	logic                    by_tag_q, by_tag_d;
	logic [VALUE_WIDTH-1:0]  res_q, res_d;
	logic [STATUS_WIDTH-1:0] stat_q, stat_d;

	logic                    out_valid_q;
	logic [VALUE_WIDTH-1:0]  result_value_q;
	logic [VALUE_WIDTH-1:0]  front_value_q;
	logic [VALUE_WIDTH-1:0]  back_value_q;
	logic [CW-1:0]           count_out_q;
	logic [STATUS_WIDTH-1:0] status_q;

	cell_ctl_t               ctl;
	logic [DATA_WIDTH-1:0]   din;
	logic [DATA_WIDTH-1:0]   data_w [DEPTH];
	logic [IW-1:0]           tag_w  [DEPTH];
	logic [DEPTH:0]          swap_w;
	logic [CW-1:0]           rd_sel;
	logic [DATA_WIDTH-1:0]   rd_data;
	logic [VALUE_WIDTH-1:0]  rd_x;
	logic [VALUE_WIDTH-1:0]  head_x;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    pos_ok;
	logic                    out_free;
	logic                    report_done;

	// Low DATA_WIDTH bits of the pushed value are kept.
	assign din = DATA_WIDTH'($unsigned(value));

	// --------------------------------------------------------------------
	// Cell row. Cell 0 takes the pushed value on a shift toward the back,
	// the last cell keeps its own entry on a shift toward the front.
	// --------------------------------------------------------------------
	assign swap_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [IW-1:0]         left_t;
		logic [DATA_WIDTH-1:0] right_d;
		logic [IW-1:0]         right_t;

		if (i == 0) begin : g_head
			assign left_d = din;
			assign left_t = tag_w[i];
		end else begin : g_mid_l
			assign left_d = data_w[i-1];
			assign left_t = tag_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_d = data_w[i];
			assign right_t = tag_w[i];
		end else begin : g_mid_r
			assign right_d = data_w[i+1];
			assign right_t = tag_w[i+1];
		end

		blws_cell #(
			.DEPTH      (DEPTH),
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.din        (din),
			.count      (count_q),
			.left_data  (left_d),
			.left_tag   (left_t),
			.right_data (right_d),
			.right_tag  (right_t),
			.swap_left  (swap_w[i]),
			.swap_right (swap_w[i+1]),
			.data       (data_w[i]),
			.tag        (tag_w[i])
		);
	end

	// --------------------------------------------------------------------
	// One read port on the row: the requested position for a read, else
	// the last entry (pop from the back, and the back value in a report).
	// --------------------------------------------------------------------
	assign accept = in_valid && !in_stall;
	assign pos_ok = PW'(position) < PW'(count_q);

	always_comb begin
		if (state_q == ST_IDLE && action == ACT_READ) begin
			rd_sel = CW'(position);
		end else begin
			rd_sel = count_q - CW'(1);
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rd_sel == CW'(i)) begin
				rd_data = data_w[i];
			end
		end
	end

	// Entries are reported as 32-bit signed values.
	if (DATA_WIDTH >= VALUE_WIDTH) begin : g_trunc
		assign rd_x   = rd_data[VALUE_WIDTH-1:0];
		assign head_x = data_w[0][VALUE_WIDTH-1:0];
	end else begin : g_sext
		assign rd_x   = {{(VALUE_WIDTH-DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
		assign head_x = {{(VALUE_WIDTH-DATA_WIDTH){data_w[0][DATA_WIDTH-1]}}, data_w[0]};
	end

	// --------------------------------------------------------------------
	// Sequencer.
	// --------------------------------------------------------------------
	assign full        = count_q == CW'(DEPTH);
	assign empty       = count_q == '0;
	assign out_free    = !out_valid_q || !out_stall;
	assign report_done = (state_q == ST_REPORT) && out_free;
	assign in_stall    = state_q != ST_IDLE;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		phases_d   = phases_q;
		parity_d   = parity_q;
		by_tag_d   = by_tag_q;
		res_d      = res_q;
		stat_d     = stat_q;
		ctl.cmd    = CMD_HOLD;
		ctl.parity = parity_q;
		ctl.by_tag = by_tag_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_d    = '0;
					stat_d   = STAT_OK;
					state_d  = ST_REPORT;
					phases_d = count_q;
					parity_d = 1'b0;
					unique case (action)
						ACT_PUSH_FRONT: begin
							if (full) begin
								stat_d = STAT_FULL;
							end else begin
								ctl.cmd = CMD_SHIFT_UP;
								count_d = count_q + CW'(1);
							end
						end
						ACT_PUSH_BACK: begin
							if (full) begin
								stat_d = STAT_FULL;
							end else begin
								ctl.cmd = CMD_WRITE;
								count_d = count_q + CW'(1);
							end
						end
						ACT_POP_FRONT: begin
							if (empty) begin
								stat_d = STAT_EMPTY;
							end else begin
								ctl.cmd = CMD_SHIFT_DOWN;
								res_d   = head_x;
								count_d = count_q - CW'(1);
							end
						end
						ACT_POP_BACK: begin
							if (empty) begin
								stat_d = STAT_EMPTY;
							end else begin
								res_d   = rd_x;
								count_d = count_q - CW'(1);
							end
						end
						ACT_READ: begin
							if (pos_ok) begin
								res_d = rd_x;
							end else begin
								stat_d = STAT_RANGE;
							end
						end
						ACT_REVERSE: begin
							ctl.cmd  = CMD_TAG;
							by_tag_d = 1'b1;
							state_d  = ST_SORT;
						end
						ACT_SORT: begin
							by_tag_d = 1'b0;
							state_d  = ST_SORT;
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SORT: begin
				// One transposition phase per entry puts the row in order.
				if (phases_q == '0) begin
					state_d = ST_REPORT;
				end else begin
					ctl.cmd  = CMD_PHASE;
					parity_d = ~parity_q;
					phases_d = phases_q - CW'(1);
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			phases_q    <= '0;
			parity_q    <= 1'b0;
			by_tag_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			phases_q <= phases_d;
			parity_q <= parity_d;
			by_tag_q <= by_tag_d;
			if (report_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: captured at accept, completed in the report cycle.
	always_ff @(posedge clk) begin
		res_q  <= res_d;
		stat_q <= stat_d;
		if (report_done) begin
			result_value_q <= res_q;
			front_value_q  <= empty ? '0 : head_x;
			back_value_q   <= empty ? '0 : rd_x;
			count_out_q    <= count_q;
			status_q       <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign front_value  = front_value_q;
	assign back_value   = back_value_q;
	assign count        = count_out_q;
	assign is_empty     = count_out_q == '0;
	assign status       = status_q;

	// --------------------------------------------------------------------
	// Assertions.
	// --------------------------------------------------------------------
	a_no_swap_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		!swap_w[DEPTH])
		else $error("last cell paired with a cell beyond the row");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_sort_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |=> $stable(count_q))
		else $error("entry count changed during a sort or reverse");

	a_simple_to_report: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action != ACT_SORT && action != ACT_REVERSE |=> state_q == ST_REPORT)
		else $error("simple action did not go straight to report");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_READ && !pos_ok |=> stat_q == STAT_RANGE && res_q == '0)
		else $error("read beyond count not flagged");

endmodule
